// File: src/ray_nearest_hit_engine_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the nearest-hit engine.
// Each macro expands to one labeled concurrent assertion that reports via
// $error and is switched off while the synchronous reset is active.
// ---------------------------------------------------------------------------
`ifndef RAY_NEAREST_HIT_ENGINE_ASSERT_SVH
`define RAY_NEAREST_HIT_ENGINE_ASSERT_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define RNHE_ASSERT_IMP(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define RNHE_ASSERT_NXT(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/rnhe_pkg.sv
// ---------------------------------------------------------------------------
// rnhe_pkg
// Types, codes and fixed-point helpers for the ray nearest-hit engine.
// ---------------------------------------------------------------------------
package rnhe_pkg;

  localparam int DEFAULT_MAX_OBJECTS = 128;
  localparam int COORD_WIDTH         = 32;
  localparam int ENTRIES_PER_OBJECT  = 12;
  localparam int COUNT_W             = 8;
  localparam int ACC_W               = 128;
  localparam int ABC_W               = 64;
  localparam int T_W                 = 31;
  localparam int FRAC_BITS           = 16;

  // Command opcodes
  localparam logic [1:0] OP_WRITE_ENTRY = 2'd0;
  localparam logic [1:0] OP_WRITE_KIND  = 2'd1;
  localparam logic [1:0] OP_TRACE       = 2'd2;

  // Object kinds
  localparam logic KIND_SPHERE = 1'b0;
  localparam logic KIND_PLANE  = 1'b1;

  // Matrix row code that carries no entry
  localparam logic [1:0] ROW_NONE = 2'd3;

  typedef struct packed {
    logic [1:0]                     opcode;
    logic [6:0]                     object_index;
    logic [1:0]                     matrix_row;
    logic [1:0]                     matrix_column;
    logic signed [COORD_WIDTH-1:0]  entry_value;
    logic                           object_kind;
    logic signed [COORD_WIDTH-1:0]  source_x;
    logic signed [COORD_WIDTH-1:0]  source_y;
    logic signed [COORD_WIDTH-1:0]  source_z;
    logic signed [COORD_WIDTH-1:0]  tip_x;
    logic signed [COORD_WIDTH-1:0]  tip_y;
    logic signed [COORD_WIDTH-1:0]  tip_z;
  } cmd_t;

  typedef struct packed {
    logic           hit;
    logic [6:0]     hit_object;
    logic [T_W-1:0] hit_distance;
  } result_t;

  // Sign-extend a coordinate to the multiplier operand width
  function automatic logic signed [ABC_W-1:0] sext_coord(
    input logic signed [COORD_WIDTH-1:0] v);
    sext_coord = {{(ABC_W-COORD_WIDTH){v[COORD_WIDTH-1]}}, v};
  endfunction

  // Magnitude of a coordinate (fits unsigned, including the most negative)
  function automatic logic [COORD_WIDTH-1:0] abs_coord(
    input logic signed [COORD_WIDTH-1:0] v);
    abs_coord = v[COORD_WIDTH-1] ? COORD_WIDTH'(-v) : v;
  endfunction

  // Floor to Q16.16 and saturate to a signed coordinate
  function automatic logic signed [COORD_WIDTH-1:0] sat_coord(
    input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0]      s;
    logic [ACC_W-COORD_WIDTH:0]   top;
    s   = v >>> FRAC_BITS;
    top = s[ACC_W-1:COORD_WIDTH-1];
    if (top == '0 || top == '1) begin
      sat_coord = s[COORD_WIDTH-1:0];
    end else if (s[ACC_W-1]) begin
      sat_coord = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    end else begin
      sat_coord = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end
  endfunction

  // Floor to Q16.16 and saturate to +-(2^62-1)
  function automatic logic signed [ABC_W-1:0] sat_abc(
    input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] s;
    logic [ACC_W-ABC_W+1:0]  top;
    s   = v >>> FRAC_BITS;
    top = s[ACC_W-1:ABC_W-2];
    if (top == '0) begin
      sat_abc = s[ABC_W-1:0];
    end else if (top == '1) begin
      if (s[ABC_W-3:0] == '0) sat_abc = {2'b11, {(ABC_W-3){1'b0}}, 1'b1};
      else                    sat_abc = s[ABC_W-1:0];
    end else if (s[ACC_W-1]) begin
      sat_abc = {2'b11, {(ABC_W-3){1'b0}}, 1'b1};
    end else begin
      sat_abc = {2'b00, {(ABC_W-2){1'b1}}};
    end
  endfunction

  // Difference of two coordinates, saturated to a coordinate
  function automatic logic signed [COORD_WIDTH-1:0] clamp_diff(
    input logic signed [COORD_WIDTH-1:0] a,
    input logic signed [COORD_WIDTH-1:0] b);
    logic signed [COORD_WIDTH:0] diff;
    diff = {a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b};
    if (diff[COORD_WIDTH] == diff[COORD_WIDTH-1]) begin
      clamp_diff = diff[COORD_WIDTH-1:0];
    end else if (diff[COORD_WIDTH]) begin
      clamp_diff = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    end else begin
      clamp_diff = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end
  endfunction

endpackage

// File: src/ray_nearest_hit_engine.sv
// ---------------------------------------------------------------------------
// ray_nearest_hit_engine
// Nearest-hit search of one ray against a table of spheres and planes.
// ---------------------------------------------------------------------------
// Load commands (start with busy low) write one matrix entry or one object
// kind and return nothing. A trace command raises busy and walks objects
// 0..N-1, N being object_count saturated to MAX_OBJECTS, on one shared 32x32
// multiplier with a 128-bit accumulator and one bit-serial divide/square-root
// unit. Per object it fetches the matrix and maps source and tip; then a plane
// object needs at most one 128-step divide and a sphere object dot products,
// the discriminant, a 64-step square root and up to two 128-step divides.
// The result is shown for exactly one cycle with done high and cannot be held
// off; the next command may be issued in that same cycle.

`include "ray_nearest_hit_engine_assert.svh"

module ray_nearest_hit_engine #(
  parameter int MAX_OBJECTS = rnhe_pkg::DEFAULT_MAX_OBJECTS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  rnhe_pkg::cmd_t               cmd,
  input  logic                         cfg_we,
  input  logic [rnhe_pkg::COUNT_W-1:0] cfg_wdata,
  output logic                         done,
  output rnhe_pkg::result_t            result
);
  import rnhe_pkg::*;

  localparam int OIW   = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
  localparam int CNT_W = $clog2(MAX_OBJECTS + 1);
  localparam int DEPTH = MAX_OBJECTS * ENTRIES_PER_OBJECT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_OBJECTS);
  localparam logic [3:0]       LAST_ENT = 4'(ENTRIES_PER_OBJECT - 1);
  localparam logic [3:0]       NUM_ENT  = 4'(ENTRIES_PER_OBJECT);

  // Sequencer states
  localparam logic [3:0] ST_IDLE       = 4'd0;
  localparam logic [3:0] ST_FETCH      = 4'd1;
  localparam logic [3:0] ST_MAP_INIT   = 4'd2;
  localparam logic [3:0] ST_MUL        = 4'd3;
  localparam logic [3:0] ST_ACC        = 4'd4;
  localparam logic [3:0] ST_MAP_STORE  = 4'd5;
  localparam logic [3:0] ST_DIR        = 4'd6;
  localparam logic [3:0] ST_DOT_STORE  = 4'd7;
  localparam logic [3:0] ST_DISC_CHECK = 4'd8;
  localparam logic [3:0] ST_SQRT       = 4'd9;
  localparam logic [3:0] ST_ROOT       = 4'd10;
  localparam logic [3:0] ST_DIV        = 4'd11;
  localparam logic [3:0] ST_ROOT_CHECK = 4'd12;
  localparam logic [3:0] ST_PLANE      = 4'd13;
  localparam logic [3:0] ST_CAND       = 4'd14;
  localparam logic [3:0] ST_DONE       = 4'd15;

  // Multiplier operand sources
  localparam logic [1:0] MODE_MAP  = 2'd0;
  localparam logic [1:0] MODE_DOT  = 2'd1;
  localparam logic [1:0] MODE_DISC = 2'd2;

  // Dot product selectors
  localparam logic [1:0] DOT_A = 2'd0;
  localparam logic [1:0] DOT_H = 2'd1;
  localparam logic [1:0] DOT_C = 2'd2;

  localparam logic [1:0] LAST_AXIS = 2'd2;
  localparam logic [1:0] LAST_PP   = 2'd3;

  // Control registers
  logic [3:0]         state;
  logic [1:0]         mode;
  logic [CNT_W-1:0]   obj;
  logic [3:0]         fcnt;
  logic               pt;
  logic [1:0]         row;
  logic [1:0]         term;
  logic [1:0]         dsel;
  logic               part;
  logic [1:0]         pp;
  logic               k;
  logic [6:0]         cnt;
  logic [COUNT_W-1:0] object_count;

  // Datapath registers
  logic signed [COORD_WIDTH-1:0] src [3];
  logic signed [COORD_WIDTH-1:0] tip [3];
  logic signed [COORD_WIDTH-1:0] sm [3];
  logic signed [COORD_WIDTH-1:0] pm [3];
  logic signed [COORD_WIDTH-1:0] d [3];
  logic signed [COORD_WIDTH-1:0] mreg [ENTRIES_PER_OBJECT];
  logic [63:0]                   prod;
  logic                          prod_neg;
  logic [1:0]                    prod_sh;
  logic signed [ACC_W-1:0]       acc;
  logic signed [ABC_W-1:0]       a_val;
  logic signed [ABC_W-1:0]       h_val;
  logic signed [ABC_W-1:0]       c_val;
  logic [63:0]                   root;
  logic [66:0]                   rem;
  logic [ACC_W-1:0]              div_num;
  logic [63:0]                   div_den;
  logic [T_W-1:0]                q;
  logic                          cand_hit;
  logic [T_W-1:0]                cand_t;
  logic                          any;
  logic [T_W-1:0]                best_t;
  logic [OIW-1:0]                best_obj;

  // Object store
  logic [COORD_WIDTH-1:0] mem [DEPTH];
  logic [COORD_WIDTH-1:0] mem_q;
  logic                   kind_mem [MAX_OBJECTS];
  logic                   kind_q;

  // Combinational signals
  logic                          take;
  logic                          idx_ok;
  logic                          wr_entry;
  logic                          wr_kind;
  logic [AW-1:0]                 wr_addr;
  logic [AW-1:0]                 rd_addr;
  logic [3:0]                    fcnt_rd;
  logic [CNT_W-1:0]              count_eff;
  logic [CNT_W-1:0]              obj_inc;
  logic [3:0]                    m_idx;
  logic signed [COORD_WIDTH-1:0] mrd;
  logic signed [ABC_W-1:0]       mul_x;
  logic signed [ABC_W-1:0]       mul_y;
  logic                          mul_sub;
  logic [63:0]                   mag_x;
  logic [63:0]                   mag_y;
  logic [31:0]                   half_x;
  logic [31:0]                   half_y;
  logic [ACC_W-1:0]              acc_term;
  logic signed [COORD_WIDTH-1:0] map_val;
  logic signed [ACC_W-1:0]       acc_c;
  logic signed [ABC_W-1:0]       dot_val;
  logic [64:0]                   div_rem_sh;
  logic                          div_ge;
  logic [64:0]                   div_rem_nx;
  logic [31:0]                   div_q_sh;
  logic [T_W-1:0]                div_q_nx;
  logic [66:0]                   sq_rem_sh;
  logic [66:0]                   sq_trial;
  logic                          sq_ge;
  logic signed [65:0]            neg_h;
  logic signed [65:0]            n_val;
  logic                          n_pos;
  logic signed [COORD_WIDTH-1:0] sz;
  logic signed [COORD_WIDTH-1:0] dz;

  assign busy = (state != ST_IDLE);
  assign take = start && !busy;

  // Decode load commands
  assign idx_ok   = (32'(cmd.object_index) < MAX_OBJECTS);
  assign wr_entry = take && (cmd.opcode == OP_WRITE_ENTRY) && (cmd.matrix_row != ROW_NONE)
                    && idx_ok;
  assign wr_kind  = take && (cmd.opcode == OP_WRITE_KIND) && idx_ok;
  assign wr_addr  = AW'({cmd.object_index, 3'b000}) + AW'({cmd.object_index, 2'b00})
                    + AW'({cmd.matrix_row, cmd.matrix_column});

  // Fetch address: object base plus entry
  assign fcnt_rd = (fcnt > LAST_ENT) ? LAST_ENT : fcnt;
  assign rd_addr = AW'({obj[OIW-1:0], 3'b000}) + AW'({obj[OIW-1:0], 2'b00}) + AW'(fcnt_rd);

  // Effective object count, saturated to the table size
  always_comb begin
    if ({{(32-COUNT_W){1'b0}}, object_count} > 32'(MAX_OBJECTS)) count_eff = CNT_MAX;
    else count_eff = CNT_W'(object_count);
  end
  assign obj_inc = obj + CNT_W'(1);

  // Matrix operand read
  assign m_idx = (state == ST_MAP_INIT) ? {row, 2'd3} : {row, term};
  assign mrd   = mreg[m_idx];

  // Select multiplier operands
  always_comb begin
    mul_sub = 1'b0;
    case (mode)
      MODE_MAP: begin
        mul_x = sext_coord(mrd);
        mul_y = pt ? sext_coord(tip[term]) : sext_coord(src[term]);
      end
      MODE_DOT: begin
        mul_x = (dsel == DOT_A) ? sext_coord(d[term]) : sext_coord(sm[term]);
        mul_y = (dsel == DOT_C) ? sext_coord(sm[term]) : sext_coord(d[term]);
      end
      default: begin
        mul_x   = part ? a_val : h_val;
        mul_y   = part ? c_val : h_val;
        mul_sub = part;
      end
    endcase
  end

  assign mag_x    = mul_x[ABC_W-1] ? 64'(-mul_x) : 64'(mul_x);
  assign mag_y    = mul_y[ABC_W-1] ? 64'(-mul_y) : 64'(mul_y);
  assign half_x   = pp[1] ? mag_x[63:32] : mag_x[31:0];
  assign half_y   = pp[0] ? mag_y[63:32] : mag_y[31:0];
  assign acc_term = {{(ACC_W-64){1'b0}}, prod} << {prod_sh, 5'd0};

  // Store conversions
  assign map_val = sat_coord(acc);
  assign acc_c   = (dsel == DOT_C) ? (acc - (ACC_W'(1) << 32)) : acc;
  assign dot_val = sat_abc(acc_c);

  // Restoring divide step, quotient saturates at its maximum
  assign div_rem_sh = {rem[63:0], div_num[ACC_W-1]};
  assign div_ge     = (div_rem_sh >= {1'b0, div_den});
  assign div_rem_nx = div_ge ? (div_rem_sh - {1'b0, div_den}) : div_rem_sh;
  assign div_q_sh   = {q, div_ge};
  assign div_q_nx   = div_q_sh[31] ? {T_W{1'b1}} : div_q_sh[T_W-1:0];

  // Digit-by-digit square root step
  assign sq_rem_sh = {rem[64:0], acc[ACC_W-1:ACC_W-2]};
  assign sq_trial  = {1'b0, root, 2'b01};
  assign sq_ge     = (sq_rem_sh >= sq_trial);

  // Root numerators -h - r and -h + r
  assign neg_h = -{{2{h_val[ABC_W-1]}}, h_val};
  assign n_val = k ? (neg_h + $signed({2'b00, root})) : (neg_h - $signed({2'b00, root}));
  assign n_pos = !n_val[65] && (n_val != '0);

  assign sz = sm[2];
  assign dz = d[2];

  // Object store: write on load, registered read for the sequencer
  always_ff @(posedge clk) begin
    if (wr_entry) mem[wr_addr] <= cmd.entry_value;
    mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_kind) kind_mem[OIW'(cmd.object_index)] <= cmd.object_kind;
    kind_q <= kind_mem[obj[OIW-1:0]];
  end

  // Sequencer and shared datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      done         <= 1'b0;
      object_count <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_we) object_count <= cfg_wdata;

      case (state)
        ST_IDLE: begin
          if (start && cmd.opcode == OP_TRACE) begin
            src[0]   <= cmd.source_x;
            src[1]   <= cmd.source_y;
            src[2]   <= cmd.source_z;
            tip[0]   <= cmd.tip_x;
            tip[1]   <= cmd.tip_y;
            tip[2]   <= cmd.tip_z;
            any      <= 1'b0;
            best_t   <= '0;
            best_obj <= '0;
            obj      <= '0;
            fcnt     <= '0;
            state    <= (count_eff == '0) ? ST_DONE : ST_FETCH;
          end
        end

        // Pull the object's twelve entries into local registers
        ST_FETCH: begin
          if (fcnt != '0) mreg[fcnt - 4'd1] <= mem_q;
          if (fcnt == NUM_ENT) begin
            pt    <= 1'b0;
            row   <= '0;
            pp    <= '0;
            mode  <= MODE_MAP;
            state <= ST_MAP_INIT;
          end else begin
            fcnt <= fcnt + 4'd1;
          end
        end

        // Seed the row sum with the translation
        ST_MAP_INIT: begin
          acc   <= {{(ACC_W-COORD_WIDTH){mrd[COORD_WIDTH-1]}}, mrd} << FRAC_BITS;
          term  <= '0;
          state <= ST_MUL;
        end

        ST_MUL: begin
          prod     <= 64'(half_x) * 64'(half_y);
          prod_neg <= mul_x[ABC_W-1] ^ mul_y[ABC_W-1] ^ mul_sub;
          prod_sh  <= {1'b0, pp[1]} + {1'b0, pp[0]};
          state    <= ST_ACC;
        end

        // Accumulate and advance the term counters
        ST_ACC: begin
          acc <= prod_neg ? (acc - acc_term) : (acc + acc_term);
          case (mode)
            MODE_MAP: begin
              if (term == LAST_AXIS) state <= ST_MAP_STORE;
              else begin
                term  <= term + 2'd1;
                state <= ST_MUL;
              end
            end
            MODE_DOT: begin
              if (term == LAST_AXIS) state <= ST_DOT_STORE;
              else begin
                term  <= term + 2'd1;
                state <= ST_MUL;
              end
            end
            default: begin
              if (pp == LAST_PP) begin
                if (!part) begin
                  part  <= 1'b1;
                  pp    <= '0;
                  state <= ST_MUL;
                end else begin
                  state <= ST_DISC_CHECK;
                end
              end else begin
                pp    <= pp + 2'd1;
                state <= ST_MUL;
              end
            end
          endcase
        end

        ST_MAP_STORE: begin
          if (pt) pm[row] <= map_val;
          else    sm[row] <= map_val;
          if (row == LAST_AXIS) begin
            if (pt) state <= ST_DIR;
            else begin
              pt    <= 1'b1;
              row   <= '0;
              state <= ST_MAP_INIT;
            end
          end else begin
            row   <= row + 2'd1;
            state <= ST_MAP_INIT;
          end
        end

        // Form the direction and branch on the object kind
        ST_DIR: begin
          d[0]     <= clamp_diff(pm[0], sm[0]);
          d[1]     <= clamp_diff(pm[1], sm[1]);
          d[2]     <= clamp_diff(pm[2], sm[2]);
          cand_hit <= 1'b0;
          cand_t   <= '0;
          k        <= 1'b0;
          if (kind_q == KIND_SPHERE) begin
            mode  <= MODE_DOT;
            dsel  <= DOT_A;
            term  <= '0;
            acc   <= '0;
            state <= ST_MUL;
          end else begin
            state <= ST_PLANE;
          end
        end

        ST_DOT_STORE: begin
          case (dsel)
            DOT_A:   a_val <= dot_val;
            DOT_H:   h_val <= dot_val;
            default: c_val <= dot_val;
          endcase
          acc  <= '0;
          term <= '0;
          if (dsel == DOT_C) begin
            // Degenerate ray: no sphere hit
            if (a_val[ABC_W-1] || a_val == '0) state <= ST_CAND;
            else begin
              mode  <= MODE_DISC;
              part  <= 1'b0;
              pp    <= '0;
              state <= ST_MUL;
            end
          end else begin
            dsel  <= dsel + 2'd1;
            state <= ST_MUL;
          end
        end

        // Drop negative discriminants, else start the square root
        ST_DISC_CHECK: begin
          if (acc[ACC_W-1]) state <= ST_CAND;
          else begin
            rem   <= '0;
            root  <= '0;
            cnt   <= 7'd63;
            state <= ST_SQRT;
          end
        end

        ST_SQRT: begin
          rem  <= sq_ge ? (sq_rem_sh - sq_trial) : sq_rem_sh;
          root <= {root[62:0], sq_ge};
          acc  <= acc <<< 2;
          if (cnt == '0) state <= ST_ROOT;
          else cnt <= cnt - 7'd1;
        end

        // Launch the divide for a positive numerator, skip otherwise
        ST_ROOT: begin
          if (n_pos) begin
            div_num <= {{(ACC_W-66){1'b0}}, n_val} << FRAC_BITS;
            div_den <= 64'(a_val);
            rem     <= '0;
            q       <= '0;
            cnt     <= 7'd127;
            state   <= ST_DIV;
          end else if (k) begin
            state <= ST_CAND;
          end else begin
            k <= 1'b1;
          end
        end

        ST_DIV: begin
          rem     <= {2'b00, div_rem_nx};
          q       <= div_q_nx;
          div_num <= div_num << 1;
          if (cnt == '0) state <= ST_ROOT_CHECK;
          else cnt <= cnt - 7'd1;
        end

        ST_ROOT_CHECK: begin
          if (kind_q == KIND_PLANE) begin
            cand_hit <= 1'b1;
            cand_t   <= q;
            state    <= ST_CAND;
          end else begin
            if (q != '0 && (!cand_hit || q < cand_t)) begin
              cand_t   <= q;
              cand_hit <= 1'b1;
            end
            if (k) state <= ST_CAND;
            else begin
              k     <= 1'b1;
              state <= ST_ROOT;
            end
          end
        end

        // Plane z=0: t = -sz/dz
        ST_PLANE: begin
          if (dz == '0) begin
            state <= ST_CAND;
          end else if (sz == '0) begin
            cand_hit <= 1'b1;
            cand_t   <= '0;
            state    <= ST_CAND;
          end else if ((!sz[COORD_WIDTH-1]) != dz[COORD_WIDTH-1]) begin
            state <= ST_CAND;
          end else begin
            div_num <= {{(ACC_W-COORD_WIDTH){1'b0}}, abs_coord(sz)} << FRAC_BITS;
            div_den <= {{(64-COORD_WIDTH){1'b0}}, abs_coord(dz)};
            rem     <= '0;
            q       <= '0;
            cnt     <= 7'd127;
            state   <= ST_DIV;
          end
        end

        // Keep the first strictly nearest hit
        ST_CAND: begin
          if (cand_hit && (!any || cand_t < best_t)) begin
            any      <= 1'b1;
            best_t   <= cand_t;
            best_obj <= obj[OIW-1:0];
          end
          if (obj_inc == count_eff) state <= ST_DONE;
          else begin
            obj   <= obj_inc;
            fcnt  <= '0;
            state <= ST_FETCH;
          end
        end

        ST_DONE: begin
          done                <= 1'b1;
          result.hit          <= any;
          result.hit_object   <= 7'(best_obj);
          result.hit_distance <= best_t;
          state               <= ST_IDLE;
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  // Checks
  `RNHE_ASSERT_NXT(a_done_pulse, clk, rst, done, !done, "done held longer than one cycle")
  `RNHE_ASSERT_IMP(a_miss_zero, clk, rst, done && !result.hit, result.hit_object == 7'd0 && result.hit_distance == '0, "miss transaction carries nonzero fields")
  `RNHE_ASSERT_IMP(a_obj_range, clk, rst, busy && state != ST_DONE, obj < count_eff, "object counter beyond object count")
  `RNHE_ASSERT_IMP(a_div_rem, clk, rst, state == ST_DIV, rem[66:64] == 3'd0 && rem[63:0] < div_den, "divider remainder not below divisor")
  `RNHE_ASSERT_NXT(a_trace_busy, clk, rst, start && !busy && cmd.opcode == OP_TRACE, busy, "trace command did not raise busy")

endmodule
